/* sv/ils_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package ils_pkg;

   localparam int DEPTH  = 64;
   localparam int CNT_W  = 7;
   localparam int DATA_W = 32;
   localparam int ACT_W  = 3;
   localparam int STAT_W = 2;

   localparam logic [ACT_W-1:0] ACT_APPEND  = 3'd0;
   localparam logic [ACT_W-1:0] ACT_INSERT  = 3'd1;
   localparam logic [ACT_W-1:0] ACT_REMOVE  = 3'd2;
   localparam logic [ACT_W-1:0] ACT_READ    = 3'd3;
   localparam logic [ACT_W-1:0] ACT_DEQUEUE = 3'd4;
   localparam logic [ACT_W-1:0] ACT_CLEAR   = 3'd5;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   typedef struct packed {
      logic [ACT_W-1:0]         action;
      logic [CNT_W-1:0]         index;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      logic [STAT_W-1:0]        status;
      logic [CNT_W-1:0]         count;
   } rsp_type;

   // broadcast to every cell
   typedef struct packed {
      logic                     ins;
      logic                     rem;
      logic [CNT_W-1:0]         index;
      logic signed [DATA_W-1:0] value;
   } cell_ctrl_type;

endpackage
`default_nettype wire

/* sv/ils_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
module ils_cell (
   input  wire logic                             clock,
   input  wire ils_pkg::cell_ctrl_type           ctrl,
   input  wire logic [ils_pkg::CNT_W-1:0]        cell_pos,
   input  wire logic signed [ils_pkg::DATA_W-1:0] left_in,
   input  wire logic signed [ils_pkg::DATA_W-1:0] right_in,
   output logic signed [ils_pkg::DATA_W-1:0]      entry_out,
   output logic signed [ils_pkg::DATA_W-1:0]      sel_out
);
   import ils_pkg::*;

   logic signed [DATA_W-1:0] entry_ff;
   logic signed [DATA_W-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.ins) begin
         if (cell_pos > ctrl.index) begin
            entry_in = left_in;
         end else if (cell_pos == ctrl.index) begin
            entry_in = ctrl.value;
         end
      end else if (ctrl.rem) begin
         if (cell_pos >= ctrl.index) begin
            entry_in = right_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_out = entry_ff;
   assign sel_out   = (cell_pos == ctrl.index) ? entry_ff : '0;

endmodule
`default_nettype wire

/* sv/indexed_list_store_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ordered list of up to 64 signed 32-bit values, front at position 0, kept in a
// row of cells that shift together: append, insert, remove, read, dequeue and
// clear are supported; a new transaction is taken every cycle while the
// result register is free or being drained; every transaction returns one
// result with the data read, a status (ok, index out of range, full, empty)
// and the count afterwards; a failed transaction changes nothing
module indexed_list_store_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire ils_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output ils_pkg::rsp_type      rsp_payload
);
   import ils_pkg::*;

   logic [CNT_W-1:0] fill_count_ff;
   logic [CNT_W-1:0] fill_count_in;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;

   cell_ctrl_type            ctrl;
   logic                     fire;
   logic                     full;
   logic                     empty;
   logic                     take_data;
   logic signed [DATA_W-1:0] read_data;

   logic signed [DATA_W-1:0] entry_w [DEPTH];
   logic signed [DATA_W-1:0] sel_w   [DEPTH];

   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign fire        = req_valid && req_ready;
   assign full        = (fill_count_ff == FULL_COUNT);
   assign empty       = (fill_count_ff == '0);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      ctrl.ins      = 1'b0;
      ctrl.rem      = 1'b0;
      ctrl.index    = req_payload.index;
      ctrl.value    = req_payload.value;
      take_data     = 1'b0;
      fill_count_in = fill_count_ff;
      rsp_in.status = ST_OK;
      case (req_payload.action)
         ACT_APPEND: begin
            ctrl.index = fill_count_ff;
            if (full) begin
               rsp_in.status = ST_FULL;
            end else begin
               ctrl.ins      = fire;
               fill_count_in = fill_count_ff + 1'b1;
            end
         end
         ACT_INSERT: begin
            if (req_payload.index > fill_count_ff) begin
               rsp_in.status = ST_RANGE;
            end else if (full) begin
               rsp_in.status = ST_FULL;
            end else begin
               ctrl.ins      = fire;
               fill_count_in = fill_count_ff + 1'b1;
            end
         end
         ACT_REMOVE: begin
            if (empty) begin
               rsp_in.status = ST_EMPTY;
            end else if (req_payload.index >= fill_count_ff) begin
               rsp_in.status = ST_RANGE;
            end else begin
               ctrl.rem      = fire;
               fill_count_in = fill_count_ff - 1'b1;
            end
         end
         ACT_READ: begin
            if (empty) begin
               rsp_in.status = ST_EMPTY;
            end else if (req_payload.index >= fill_count_ff) begin
               rsp_in.status = ST_RANGE;
            end else begin
               take_data = 1'b1;
            end
         end
         ACT_DEQUEUE: begin
            ctrl.index = '0;
            if (empty) begin
               rsp_in.status = ST_EMPTY;
            end else begin
               ctrl.rem      = fire;
               take_data     = 1'b1;
               fill_count_in = fill_count_ff - 1'b1;
            end
         end
         ACT_CLEAR: begin
            fill_count_in = '0;
         end
         default: begin
         end
      endcase
      rsp_in.data  = take_data ? read_data : '0;
      rsp_in.count = fill_count_in;
   end

   always_comb begin
      read_data = '0;
      for (int i = 0; i < DEPTH; i++) begin
         read_data = read_data | sel_w[i];
      end
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      ils_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .cell_pos  (CNT_W'(g)),
         .left_in   ((g == 0) ? ctrl.value : entry_w[(g == 0) ? 0 : g - 1]),
         .right_in  ((g == DEPTH - 1) ? entry_w[g] : entry_w[(g == DEPTH - 1) ? g : g + 1]),
         .entry_out (entry_w[g]),
         .sel_out   (sel_w[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (fire) begin
            fill_count_ff <= fill_count_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
`default_nettype wire

/* verif/indexed_list_store_checker.sv */
`timescale 1ns / 1ps
module indexed_list_store_checker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_ready,
   input  wire ils_pkg::req_type req_payload,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_ready,
   input  wire ils_pkg::rsp_type rsp_payload,
   output int                    mismatch_count,
   output int                    outstanding,
   output int                    list_size
);
   import ils_pkg::*;

   logic signed [DATA_W-1:0] list_values[$];
   rsp_type                  pending_rsps[$];

   function automatic rsp_type apply_command(req_type cmd);
      rsp_type r;
      int      pos;
      r.data   = '0;
      r.status = ST_OK;
      pos      = int'(cmd.index);
      case (cmd.action)
         ACT_APPEND: begin
            if (list_values.size() >= DEPTH) r.status = ST_FULL;
            else list_values.push_back(cmd.value);
         end
         ACT_INSERT: begin
            if (pos > list_values.size()) r.status = ST_RANGE;
            else if (list_values.size() >= DEPTH) r.status = ST_FULL;
            else list_values.insert(pos, cmd.value);
         end
         ACT_REMOVE: begin
            if (list_values.size() == 0) r.status = ST_EMPTY;
            else if (pos >= list_values.size()) r.status = ST_RANGE;
            else list_values.delete(pos);
         end
         ACT_READ: begin
            if (list_values.size() == 0) r.status = ST_EMPTY;
            else if (pos >= list_values.size()) r.status = ST_RANGE;
            else r.data = list_values[pos];
         end
         ACT_DEQUEUE: begin
            if (list_values.size() == 0) r.status = ST_EMPTY;
            else r.data = list_values.pop_front();
         end
         ACT_CLEAR: list_values.delete();
         default: ;
      endcase
      r.count = CNT_W'(list_values.size());
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         list_values.delete();
         pending_rsps.delete();
      end else begin
         if (req_valid && req_ready) pending_rsps.push_back(apply_command(req_payload));
         if (rsp_valid && rsp_ready) begin
            got = rsp_payload;
            if (pending_rsps.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected transaction: data %0d status %0d count %0d",
                           got.data, got.status, got.count);
            end else begin
               want = pending_rsps.pop_front();
               if (got.data !== want.data || got.status !== want.status ||
                   got.count !== want.count) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: expected data %0d status %0d count %0d, got data %0d status %0d count %0d",
                              want.data, want.status, want.count,
                              got.data, got.status, got.count);
               end
            end
         end
      end
      outstanding = pending_rsps.size();
      list_size   = list_values.size();
   end

endmodule

/* verif/indexed_list_store_core_tb.sv */
`timescale 1ns / 1ps
module indexed_list_store_core_tb;
   import ils_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int INDEX_MAX   = (1 << CNT_W) - 1;
   localparam int ACTION_MAX  = (1 << ACT_W) - 1;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;

   int mismatch_count;
   int outstanding;
   int list_size;
   int send_idle_pct;
   int recv_idle_pct;
   int stall_left;
   int cycle_count;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   indexed_list_store_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   indexed_list_store_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_payload    (rsp_payload),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding),
      .list_size      (list_size)
   );

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // receiver side, long hold-off counted down here
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_cmd(input logic [ACT_W-1:0] act, input int idx,
                           input logic signed [DATA_W-1:0] val);
      req_type cmd;
      cmd.action = act;
      cmd.index  = CNT_W'(idx);
      cmd.value  = val;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= cmd;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct, input bit with_hold);
      int                       pick;
      int                       idx;
      logic [ACT_W-1:0]         act;
      logic signed [DATA_W-1:0] val;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      // fill to the top, then push against the full list
      repeat (DEPTH + 4) send_cmd(ACT_APPEND, $urandom_range(INDEX_MAX, 0), $urandom());
      send_cmd(ACT_INSERT, DEPTH, $urandom());
      send_cmd(ACT_INSERT, $urandom_range(INDEX_MAX, DEPTH + 1), $urandom());
      send_cmd(ACT_INSERT, $urandom_range(DEPTH - 1, 0), $urandom());
      if (with_hold) stall_left = 300;
      repeat (80) begin
         pick = $urandom_range(99);
         if (pick < 25) act = ACT_APPEND;
         else if (pick < 45) act = ACT_INSERT;
         else if (pick < 60) act = ACT_REMOVE;
         else if (pick < 80) act = ACT_READ;
         else if (pick < 94) act = ACT_DEQUEUE;
         else if (pick < 97) act = ACT_CLEAR;
         else act = ACT_W'($urandom_range(ACTION_MAX, int'(ACT_CLEAR) + 1));
         if ($urandom_range(99) < 80) idx = $urandom_range(list_size, 0);
         else idx = $urandom_range(INDEX_MAX, 0);
         case ($urandom_range(19))
            0:       val = {1'b1, {(DATA_W-1){1'b0}}};
            1:       val = {1'b0, {(DATA_W-1){1'b1}}};
            2:       val = '1;
            3:       val = '0;
            default: val = $urandom();
         endcase
         send_cmd(act, idx, val);
      end
      repeat (list_size + 2) send_cmd(ACT_DEQUEUE, $urandom_range(INDEX_MAX, 0), $urandom());
      wait_drained();
   endtask

   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_payload   <= '0;
      send_idle_pct = 30;
      recv_idle_pct = 51;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_cmd(ACT_READ, 0, 0);
      send_cmd(ACT_REMOVE, 0, 0);
      send_cmd(ACT_DEQUEUE, 0, 0);
      send_cmd(ACT_INSERT, 1, 5);
      send_cmd(ACT_INSERT, 0, {1'b0, {(DATA_W-1){1'b1}}});
      send_cmd(ACT_APPEND, 0, {1'b1, {(DATA_W-1){1'b0}}});
      send_cmd(ACT_APPEND, 0, '1);
      send_cmd(ACT_APPEND, 0, '0);
      send_cmd(ACT_INSERT, 4, 5);
      send_cmd(ACT_INSERT, 0, 11);
      send_cmd(ACT_INSERT, 2, -7);
      send_cmd(ACT_READ, 0, 0);
      send_cmd(ACT_READ, 6, 0);
      send_cmd(ACT_READ, 7, 0);
      send_cmd(ACT_READ, INDEX_MAX, 0);
      send_cmd(ACT_REMOVE, INDEX_MAX, 0);
      send_cmd(ACT_REMOVE, 7, 0);
      send_cmd(ACT_REMOVE, 2, 0);
      send_cmd(ACT_REMOVE, 0, 0);
      send_cmd(ACT_DEQUEUE, 0, 0);
      send_cmd(ACT_W'(ACTION_MAX - 1), INDEX_MAX, $urandom());
      send_cmd(ACT_W'(ACTION_MAX), INDEX_MAX, $urandom());
      send_cmd(ACT_CLEAR, 0, 0);
      send_cmd(ACT_CLEAR, 0, 0);
      wait_drained();

      run_phase(30, 51, 1'b1);
      run_phase(51, 30, 1'b0);
      run_phase(0, 0, 1'b1);

      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
